/* rtl/mmbd_pkg.sv */
// Package for the memory map bus decoder: word types, operation codes,
// address map constants and memory sizes. Depends on nothing.
package mmbd_pkg;

    typedef enum logic [1:0] {
        OP_READ      = 2'd0,
        OP_CPU_WRITE = 2'd1,
        OP_HW_WRITE  = 2'd2,
        OP_ROM_LOAD  = 2'd3
    } t_op;

    typedef struct packed {
        t_op         operation;
        logic [15:0] address;
        logic [7:0]  data;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic       serial_valid;
        logic [7:0] serial_byte;
    } t_out_word;

    typedef enum logic [1:0] {
        RG_NONE = 2'd0,
        RG_MAIN = 2'd1,
        RG_HIGH = 2'd2
    } t_region;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } t_state;

    localparam logic [15:0] ADDR_ROM_HI    = 16'h7FFF;
    localparam logic [15:0] ADDR_VRAM_LO   = 16'h8000;
    localparam logic [15:0] ADDR_WRAM_HI   = 16'hDFFF;
    localparam logic [15:0] ADDR_OAM_LO    = 16'hFE00;
    localparam logic [15:0] ADDR_OAM_HI    = 16'hFE9F;
    localparam logic [15:0] ADDR_IO_LO     = 16'hFF00;
    localparam logic [15:0] ADDR_IO_HI     = 16'hFF7F;
    localparam logic [15:0] ADDR_HRAM_HI   = 16'hFFFE;
    localparam logic [15:0] ADDR_DIV       = 16'hFF04;
    localparam logic [15:0] ADDR_SB        = 16'hFF01;
    localparam logic [15:0] ADDR_SC        = 16'hFF02;
    localparam logic [7:0]  SC_START       = 8'h81;

    localparam int          MAIN_DEPTH     = 57344;
    localparam int          MAIN_AW        = 16;
    localparam int          HIGH_DEPTH     = 512;
    localparam int          HIGH_AW        = 9;
    localparam logic [15:0] CLEAR_LAST     = 16'hDFFF;

    typedef struct packed {
        logic                main_we;
        logic [MAIN_AW-1:0]  main_addr;
        logic                high_we;
        logic [HIGH_AW-1:0]  high_waddr;
        logic [7:0]          high_wdata;
        logic [HIGH_AW-1:0]  high_raddr;
    } t_mem_ctl;

    typedef struct packed {
        logic    is_read;
        t_region region;
        logic    serial;
    } t_result_sel;

endpackage

/* rtl/mmbd_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module mmbd_ram #(
    parameter  int DEPTH = 512,
    parameter  int DW    = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:DEPTH-1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mmbd_decode.sv */
// Address and operation decode: memory strobes, addresses and write data,
// and the selection that shapes the result word. Depends on mmbd_pkg.
module mmbd_decode (
    input  mmbd_pkg::t_in_word    i_word,
    output mmbd_pkg::t_mem_ctl    o_ctl,
    output mmbd_pkg::t_result_sel o_sel
);

    logic in_main;
    logic in_vram_wram;
    logic in_rom;
    logic in_oam;
    logic in_io;
    logic in_hram;
    logic serial;

    always_comb begin
        in_rom       = i_word.address <= mmbd_pkg::ADDR_ROM_HI;
        in_main      = i_word.address <= mmbd_pkg::ADDR_WRAM_HI;
        in_vram_wram = i_word.address inside
                       {[mmbd_pkg::ADDR_VRAM_LO:mmbd_pkg::ADDR_WRAM_HI]};
        in_oam       = i_word.address inside
                       {[mmbd_pkg::ADDR_OAM_LO:mmbd_pkg::ADDR_OAM_HI]};
        in_io        = i_word.address inside
                       {[mmbd_pkg::ADDR_IO_LO:mmbd_pkg::ADDR_IO_HI]};
        in_hram      = i_word.address inside
                       {[mmbd_pkg::ADDR_IO_LO:mmbd_pkg::ADDR_HRAM_HI]};
        serial       = (i_word.operation == mmbd_pkg::OP_CPU_WRITE)
                       && (i_word.address == mmbd_pkg::ADDR_SC)
                       && (i_word.data == mmbd_pkg::SC_START);

        o_ctl.main_addr  = i_word.address[mmbd_pkg::MAIN_AW-1:0];
        o_ctl.high_waddr = i_word.address[mmbd_pkg::HIGH_AW-1:0];
        o_ctl.high_wdata = i_word.data;
        o_ctl.high_raddr = serial ? mmbd_pkg::ADDR_SB[mmbd_pkg::HIGH_AW-1:0]
                                  : i_word.address[mmbd_pkg::HIGH_AW-1:0];
        o_ctl.main_we    = 1'b0;
        o_ctl.high_we    = 1'b0;

        o_sel.is_read = 1'b0;
        o_sel.region  = mmbd_pkg::RG_NONE;
        o_sel.serial  = serial;

        case (i_word.operation)
            mmbd_pkg::OP_READ: begin
                o_sel.is_read = 1'b1;
                if (in_main) begin
                    o_sel.region = mmbd_pkg::RG_MAIN;
                end else if (in_oam || in_hram) begin
                    o_sel.region = mmbd_pkg::RG_HIGH;
                end
            end
            mmbd_pkg::OP_CPU_WRITE: begin
                o_ctl.main_we = in_vram_wram;
                o_ctl.high_we = in_oam || in_hram;
                if (i_word.address == mmbd_pkg::ADDR_DIV || serial) begin
                    o_ctl.high_wdata = 8'h00;
                end
            end
            mmbd_pkg::OP_HW_WRITE: begin
                o_ctl.high_we = in_io;
            end
            mmbd_pkg::OP_ROM_LOAD: begin
                o_ctl.main_we = in_rom;
            end
            default: begin
                o_ctl.main_we = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/memory_map_bus_decoder.sv */
// Top level of the memory map bus decoder: clearing sequencer, two stores
// and result register. Depends on mmbd_pkg, mmbd_decode and mmbd_ram.
//
// One word is taken per clock while busy is low and start is high, and its
// result appears on o_word with o_strobe in the cycle after; the receiver cannot
// stall, so back-to-back words give back-to-back results. ROM, video, external
// and work RAM share one 57344-byte store, the sprite table, I/O and high RAM a
// 512-byte store, each with a registered read. After reset the block clears
// both stores, one entry per cycle, and holds busy high until the clearing is
// done, so no word is taken before then.
module memory_map_bus_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  mmbd_pkg::t_in_word  i_word,
    output logic                o_strobe,
    output mmbd_pkg::t_out_word o_word
);

    mmbd_pkg::t_state      r_state;
    mmbd_pkg::t_state      n_state;
    logic [15:0]           r_clr_cnt;
    logic [15:0]           n_clr_cnt;
    logic                  r_strobe;
    logic                  n_strobe;
    mmbd_pkg::t_result_sel r_sel;
    mmbd_pkg::t_mem_ctl    dec_ctl;
    mmbd_pkg::t_result_sel dec_sel;
    logic                  accept;

    logic                          main_we;
    logic [mmbd_pkg::MAIN_AW-1:0]  main_waddr;
    logic [7:0]                    main_wdata;
    logic [7:0]                    main_rdata;
    logic                          high_we;
    logic [mmbd_pkg::HIGH_AW-1:0]  high_waddr;
    logic [7:0]                    high_wdata;
    logic [7:0]                    high_rdata;

    mmbd_decode u_decode (
        .i_word (i_word),
        .o_ctl  (dec_ctl),
        .o_sel  (dec_sel)
    );

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        busy      = 1'b1;
        accept    = 1'b0;
        case (r_state)
            mmbd_pkg::ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 16'd1;
                if (r_clr_cnt == mmbd_pkg::CLEAR_LAST) begin
                    n_state = mmbd_pkg::ST_RUN;
                end
            end
            mmbd_pkg::ST_RUN: begin
                busy   = 1'b0;
                accept = start;
            end
            default: begin
                n_state = mmbd_pkg::ST_CLEAR;
            end
        endcase
        n_strobe = accept;

        if (r_state == mmbd_pkg::ST_CLEAR) begin
            main_we    = 1'b1;
            main_waddr = r_clr_cnt[mmbd_pkg::MAIN_AW-1:0];
            main_wdata = 8'h00;
            high_we    = r_clr_cnt[15:mmbd_pkg::HIGH_AW] == '0;
            high_waddr = r_clr_cnt[mmbd_pkg::HIGH_AW-1:0];
            high_wdata = 8'h00;
        end else begin
            main_we    = accept && dec_ctl.main_we;
            main_waddr = dec_ctl.main_addr;
            main_wdata = i_word.data;
            high_we    = accept && dec_ctl.high_we;
            high_waddr = dec_ctl.high_waddr;
            high_wdata = dec_ctl.high_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mmbd_pkg::ST_CLEAR;
            r_clr_cnt <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sel <= dec_sel;
        end
    end

    mmbd_ram #(
        .DEPTH (mmbd_pkg::MAIN_DEPTH),
        .DW    (8)
    ) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (main_we),
        .i_waddr (main_waddr),
        .i_wdata (main_wdata),
        .i_raddr (dec_ctl.main_addr),
        .o_rdata (main_rdata)
    );

    mmbd_ram #(
        .DEPTH (mmbd_pkg::HIGH_DEPTH),
        .DW    (8)
    ) u_high_ram (
        .i_clk   (i_clk),
        .i_we    (high_we),
        .i_waddr (high_waddr),
        .i_wdata (high_wdata),
        .i_raddr (dec_ctl.high_raddr),
        .o_rdata (high_rdata)
    );

    always_comb begin
        o_word.read_data = 8'h00;
        if (r_sel.is_read) begin
            case (r_sel.region)
                mmbd_pkg::RG_MAIN: o_word.read_data = main_rdata;
                mmbd_pkg::RG_HIGH: o_word.read_data = high_rdata;
                default:           o_word.read_data = 8'h00;
            endcase
        end
        o_word.serial_valid = r_sel.serial;
        o_word.serial_byte  = r_sel.serial ? high_rdata : 8'h00;
    end

    assign o_strobe = r_strobe;

endmodule
